// ===== src/fac_pkg.sv =====
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants of the frame autocorrelation block.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int SAMPLE_W    = 16;  // width of the sample field on the port
  localparam int VALUE_W     = 44;  // width of one autocorrelation value
  localparam int LAG_W       = 5;   // width of the lag index and the order
  localparam int ORDER_RESET = 25;  // order after reset

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
  } fac_req_t;

  typedef struct packed {
    logic [LAG_W-1:0]          lag;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } fac_rsp_t;

endpackage

// ===== src/fac_mac_cell.sv =====
// ----------------------------------------------------------------------------
// fac_mac_cell
// One lag accumulator: multiply, add and saturate to +/-2^(VALUE_W-2).
// ----------------------------------------------------------------------------
module fac_mac_cell import fac_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,     // an item is accumulated
  input  logic                          clear_i,   // frame ends with this item
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] tap_i,
  output logic signed [VALUE_W-1:0]     sum_o      // sum including this item
);

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SUM_W  = ((PROD_W > VALUE_W) ? PROD_W : VALUE_W) + 1;
  localparam logic signed [SUM_W-1:0] POS_LIM =
    {{(SUM_W-VALUE_W+1){1'b0}}, 1'b1, {(VALUE_W-2){1'b0}}};
  localparam logic signed [SUM_W-1:0] NEG_LIM = -POS_LIM;

  logic signed [VALUE_W-1:0] acc_q, acc_d;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;

  always_comb begin
    prod = x_i * tap_i;
    sum  = SUM_W'(acc_q) + SUM_W'(prod);
    if (sum > POS_LIM) begin
      sum_o = VALUE_W'(POS_LIM);
    end else if (sum < NEG_LIM) begin
      sum_o = VALUE_W'(NEG_LIM);
    end else begin
      sum_o = VALUE_W'(sum);
    end
    acc_d = acc_q;
    if (adv_i) begin
      acc_d = clear_i ? '0 : sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== src/fac_drain.sv =====
// ----------------------------------------------------------------------------
// fac_drain
// Snapshot bank of one frame's sums, shifted out one lag per request.
// ----------------------------------------------------------------------------
module fac_drain import fac_pkg::*; #(
  parameter int NUM_LAGS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic signed [VALUE_W-1:0] sums_i [NUM_LAGS],
  input  logic [LAG_W-1:0]          top_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fac_rsp_t                  out_rsp_o
);

  logic signed [VALUE_W-1:0] snap_q [NUM_LAGS];
  logic [LAG_W-1:0]          lag_q, lag_d, top_q, top_d;
  logic                      busy_q, busy_d;
  logic                      fire, is_last;

  always_comb begin
    is_last = (lag_q == top_q);
    fire    = busy_q && !out_stall_i;
    free_o  = !busy_q || (fire && is_last);
    busy_d  = busy_q;
    lag_d   = lag_q;
    top_d   = top_q;
    if (fire) begin
      lag_d = lag_q + LAG_W'(1);
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      lag_d  = '0;
      top_d  = top_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lag_q  <= '0;
      top_q  <= '0;
    end else begin
      busy_q <= busy_d;
      lag_q  <= lag_d;
      top_q  <= top_d;
    end
  end

  // Payload: load a whole frame, or shift down by one lag per request.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= sums_i;
    end else if (fire) begin
      for (int i = 0; i < NUM_LAGS - 1; i++) begin
        snap_q[i] <= snap_q[i+1];
      end
    end
  end

  assign out_valid_o     = busy_q;
  assign out_rsp_o.lag   = lag_q;
  assign out_rsp_o.value = snap_q[0];
  assign out_rsp_o.last  = is_last;

`ifndef NO_ASSERTIONS
  a_lag_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (lag_q <= top_q))
    else $error("lag counter ran past the frame's top lag");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("snapshot loaded over a frame still draining");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && is_last && !load_i) |=> !busy_q)
    else $error("drain kept running after its last lag");

  a_restart_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (busy_q && lag_q == '0))
    else $error("new frame did not start at lag zero");
`endif

endmodule

// ===== src/frame_autocorrelation.sv =====
// ----------------------------------------------------------------------------
// frame_autocorrelation
// Short-time autocorrelation of framed samples with saturating lag sums.
// ----------------------------------------------------------------------------
// The block takes one sample request per cycle, bar the wait below. A sample
// is first held in an input register; from there every lag cell multiplies it
// with its delay-line tap and adds the product into its own accumulator,
// saturating at +/-2^42, so all MAX_ORDER+1 lags update in parallel. When the
// sample marked frame_end is accumulated, the finished sums are copied into a
// snapshot bank, the accumulators and delay line are cleared, and the next
// frame may start at once. The snapshot then yields order+1 result requests,
// r[0] first, one per cycle while the output is not stalled, the first one
// the cycle after the frame-end sample left the input register; the last
// request carries last=1. order is clamped to MAX_ORDER, and the value in
// force when the frame-end sample is accumulated decides the count. The only
// wait on the input side: a frame-end sample holds in the input register
// while the previous frame's snapshot is still draining, which happens only
// for frames shorter than order+1 samples or under output stall. Lags longer
// than the frame read zero. With SAMPLE_BITS below 16 the low bits of the
// sample field are used; above 16 the field is taken as unsigned.
// ----------------------------------------------------------------------------
module frame_autocorrelation import fac_pkg::*; #(
  parameter int MAX_ORDER   = 31,
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LAG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fac_req_t         in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fac_rsp_t         out_rsp_o
);

  localparam int NUM_LAGS = MAX_ORDER + 1;

  logic [LAG_W-1:0]              order_q;
  logic [LAG_W-1:0]              top;
  logic                          in_fire;
  logic                          valid_q;
  logic                          end_q;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] dly_q [MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] taps  [NUM_LAGS];
  logic signed [VALUE_W-1:0]     sums  [NUM_LAGS];
  logic                          adv;
  logic                          load;
  logic                          snap_free;

  // Order register; the user must write it only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= LAG_W'(ORDER_RESET);
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  assign top = (int'(order_q) > MAX_ORDER) ? LAG_W'(MAX_ORDER) : order_q;

  // Take the sample at its configured width.
  generate
    if (SAMPLE_BITS <= SAMPLE_W) begin : g_narrow
      assign x_in = in_req_i.sample[SAMPLE_BITS-1:0];
    end else begin : g_wide
      assign x_in = {{(SAMPLE_BITS-SAMPLE_W){1'b0}}, in_req_i.sample};
    end
  endgenerate

  // Advance the held sample unless it closes a frame while the snapshot
  // is still busy with the previous one.
  assign adv        = valid_q && (!end_q || snap_free);
  assign load       = adv && end_q;
  assign in_stall_o = valid_q && !adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_fire) begin
      valid_q <= 1'b1;
    end else if (adv) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q   <= x_in;
      end_q <= in_req_i.frame_end;
    end
  end

  // Delay line: shift in each sample, drop the whole history at frame end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        dly_q[i] <= '0;
      end
    end else if (adv) begin
      if (end_q) begin
        for (int i = 0; i < MAX_ORDER; i++) begin
          dly_q[i] <= '0;
        end
      end else begin
        dly_q[0] <= x_q;
        for (int i = 1; i < MAX_ORDER; i++) begin
          dly_q[i] <= dly_q[i-1];
        end
      end
    end
  end

  // Lag zero squares the sample; lag k pairs it with the sample k back.
  assign taps[0] = x_q;
  generate
    for (genvar k = 1; k < NUM_LAGS; k++) begin : g_tap
      assign taps[k] = dly_q[k-1];
    end
    for (genvar k = 0; k < NUM_LAGS; k++) begin : g_cell
      fac_mac_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .adv_i   (adv),
        .clear_i (end_q),
        .x_i     (x_q),
        .tap_i   (taps[k]),
        .sum_o   (sums[k])
      );
    end
  endgenerate

  // Snapshot and output: one lag per result request.
  fac_drain #(
    .NUM_LAGS (NUM_LAGS)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .sums_i      (sums),
    .top_i       (top),
    .free_o      (snap_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (valid_q && end_q))
    else $error("input stalled while no frame end was held");

  a_held_sample_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !adv) |=> (valid_q && $stable(x_q) && $stable(end_q)))
    else $error("held sample changed before it was accumulated");

  a_load_starts_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("frame end produced no result");
`endif

endmodule
